// ===== hdl/assert_macros.svh =====
// assertion helpers for the checker file lr4hp_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define LR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds during reset
`define LR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lr4hp_pkg.sv =====
package lr4hp_pkg;

    localparam int CHAN_W          = 3;
    localparam int COEF_BITS       = 32;
    localparam int NUM_COEFS       = 7;
    localparam int ACC_W           = 64;
    localparam int ADDR_W          = 5;
    localparam int APB_DATA_W      = 32;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_FRAC_DEF   = 28;

    // coefficient register indexes
    typedef enum logic [2:0] {
        REG_A0 = 3'd0,
        REG_A1 = 3'd1,
        REG_A2 = 3'd2,
        REG_B1 = 3'd3,
        REG_B2 = 3'd4,
        REG_B3 = 3'd5,
        REG_B4 = 3'd6
    } t_reg_idx;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    // history access for the item in the input register
    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] chan;
    } t_hist_ctl;

endpackage

// ===== hdl/lr4hp_hist.sv =====
module lr4hp_hist #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lr4hp_pkg::t_hist_ctl          i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    output logic signed [SAMPLE_BITS-1:0] o_x_hist [4],
    output logic signed [SAMPLE_BITS-1:0] o_y_hist [4]
);
    import lr4hp_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [SAMPLE_BITS-1:0] r_x [CHANNELS][4];
    logic signed [SAMPLE_BITS-1:0] r_y [CHANNELS][4];
    logic [IDX_W-1:0]              w_idx;

    assign w_idx = IDX_W'(i_ctl.chan);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_x_hist[k] = r_x[w_idx][k];
            o_y_hist[k] = r_y[w_idx][k];
        end
    end

    // shift one channel's delay lines, newest word at place 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_x[c][k] <= '0;
                    r_y[c][k] <= '0;
                end
            end
        end else if (i_ctl.en) begin
            r_x[w_idx][0] <= i_x;
            r_y[w_idx][0] <= i_y;
            for (int k = 1; k < 4; k++) begin
                r_x[w_idx][k] <= r_x[w_idx][k-1];
                r_y[w_idx][k] <= r_y[w_idx][k-1];
            end
        end
    end

endmodule

// ===== hdl/lr4hp_regs.sv =====
module lr4hp_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lr4hp_pkg::ADDR_W-1:0]         paddr,
    input  logic [lr4hp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lr4hp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output lr4hp_pkg::t_coef                     o_coef [lr4hp_pkg::NUM_COEFS]
);
    import lr4hp_pkg::*;

    t_coef      r_coef [NUM_COEFS];
    logic [2:0] w_idx;
    logic       w_hit;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_hit  = (32'(w_idx) < NUM_COEFS);
    assign pready = 1'b1;
    assign prdata = w_hit ? APB_DATA_W'(r_coef[w_idx]) : '0;

    always_comb begin
        for (int k = 0; k < NUM_COEFS; k++) begin
            o_coef[k] = r_coef[k];
        end
    end

    // writes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_coef[w_idx] <= COEF_BITS'(pwdata);
        end
    end

endmodule

// ===== hdl/lr4hp_mac.sv =====
module lr4hp_mac #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_x_hist [4],
    input  logic signed [SAMPLE_BITS-1:0] i_y_hist [4],
    input  lr4hp_pkg::t_coef              i_coef [lr4hp_pkg::NUM_COEFS],
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import lr4hp_pkg::*;

    localparam int TERM_W = SAMPLE_BITS + 1;
    localparam int PROD_W = COEF_BITS + TERM_W;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] YMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] YMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [TERM_W-1:0]  w_term [NUM_COEFS];
    logic signed [ACC_W-1:0]   w_prod [NUM_COEFS];
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_shift;
    logic [ACC_W-SAMPLE_BITS:0] w_top;

    // symmetric taps are pre-added
    always_comb begin
        w_term[REG_A0] = TERM_W'(i_x) + TERM_W'(i_x_hist[3]);
        w_term[REG_A1] = TERM_W'(i_x_hist[0]) + TERM_W'(i_x_hist[2]);
        w_term[REG_A2] = TERM_W'(i_x_hist[1]);
        w_term[REG_B1] = TERM_W'(i_y_hist[0]);
        w_term[REG_B2] = TERM_W'(i_y_hist[1]);
        w_term[REG_B3] = TERM_W'(i_y_hist[2]);
        w_term[REG_B4] = TERM_W'(i_y_hist[3]);
    end

    // seven parallel products, each cast to the accumulator width
    always_comb begin
        logic signed [PROD_W-1:0] pf;
        for (int k = 0; k < NUM_COEFS; k++) begin
            pf        = i_coef[k] * w_term[k];
            w_prod[k] = ACC_W'(pf);
        end
    end

    assign w_acc = w_prod[REG_A0] + w_prod[REG_A1] + w_prod[REG_A2]
                 - w_prod[REG_B1] - w_prod[REG_B2] - w_prod[REG_B3]
                 - w_prod[REG_B4] + RND;

    assign w_shift = w_acc >>> COEF_FRAC_BITS;
    assign w_top   = w_shift[ACC_W-1:SAMPLE_BITS-1];

    // saturate when the bits above the sample are not a sign extension
    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_y = w_shift[SAMPLE_BITS-1:0];
        end else if (w_shift[ACC_W-1]) begin
            o_y = YMIN;
        end else begin
            o_y = YMAX;
        end
    end

endmodule

// ===== hdl/linkwitz_riley4_highpass.sv =====
// channel | direction | handshake                    | payload
// s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata: sample, tuser: channel
// m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: sample, tuser: channel
// apb     | in        | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// one item per clock while the output is not stalled; a beat passes the input register, then the output register
// the whole filter (seven products, sum, round, saturate) sits between the
// input register and the output register, so a channel's feedback is ready
// for the very next beat of that channel
// synchronous active-low reset clears coefficients and all channel histories
// input stalls only when both the input and output registers hold beats
module linkwitz_riley4_highpass #(
    parameter int CHANNELS       = lr4hp_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = lr4hp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = lr4hp_pkg::COEF_FRAC_DEF,
    localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [TDATA_W-1:0]                   s_axis_tdata,  // in_sample, pad
    input  logic [lr4hp_pkg::CHAN_W-1:0]         s_axis_tuser,  // in_channel
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [TDATA_W-1:0]                   m_axis_tdata,  // out_sample, zero pad
    output logic [lr4hp_pkg::CHAN_W-1:0]         m_axis_tuser,  // out_channel
    // coefficient registers
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lr4hp_pkg::ADDR_W-1:0]         paddr,
    input  logic [lr4hp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lr4hp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import lr4hp_pkg::*;

    // input register
    logic                          r_in_valid, n_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic [CHAN_W-1:0]             r_in_chan;
    // output register
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic [CHAN_W-1:0]             r_out_chan;

    logic                          w_s_beat;
    logic                          w_advance;
    logic                          w_in_range;
    t_hist_ctl                     w_hist_ctl;
    t_coef                         w_coef [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] w_x_hist [4];
    logic signed [SAMPLE_BITS-1:0] w_y_hist [4];
    logic signed [SAMPLE_BITS-1:0] w_y;

    // the item moves on whenever the output register is free or drains now
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_beat      = s_axis_tvalid && s_axis_tready;

    // channels past the configured count give zero and leave history alone
    assign w_in_range    = (32'(r_in_chan) < CHANNELS);

    assign w_hist_ctl.en   = w_advance && w_in_range;
    assign w_hist_ctl.chan = r_in_chan;

    assign n_in_valid  = w_s_beat || (r_in_valid && !w_advance);
    assign n_out_valid = w_advance || (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_chan   <= s_axis_tuser;
        end
        if (w_advance) begin
            r_out_sample <= w_in_range ? w_y : '0;
            r_out_chan   <= r_in_chan;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'($unsigned(r_out_sample));
    assign m_axis_tuser  = r_out_chan;

    lr4hp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    lr4hp_hist #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_hist_ctl),
        .i_x      (r_in_sample),
        .i_y      (w_y),
        .o_x_hist (w_x_hist),
        .o_y_hist (w_y_hist)
    );

    lr4hp_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_x      (r_in_sample),
        .i_x_hist (w_x_hist),
        .i_y_hist (w_y_hist),
        .i_coef   (w_coef),
        .o_y      (w_y)
    );

endmodule

// ===== hdl/lr4hp_chk.sv =====
`include "assert_macros.svh"

module lr4hp_chk #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [TDATA_W-1:0]            m_axis_tdata,
    input logic [lr4hp_pkg::CHAN_W-1:0]  m_axis_tuser,
    input logic                          pready
);
    import lr4hp_pkg::*;

    // a stalled output beat holds still
    `LR_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    // input backpressure only comes from a blocked output
    `LR_ASSERT(a_stall_cause, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled while output free")

    // unknown channels produce silence
    `LR_ASSERT(a_bad_chan_zero, i_clk, i_rst_n, m_axis_tvalid && (32'(m_axis_tuser) >= CHANNELS) |-> m_axis_tdata == '0, "nonzero sample on unused channel")

    // no output beat right after reset
    `LR_ASSERT(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n) |-> !m_axis_tvalid, "output valid right after reset")

    `LR_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "register port not ready")

endmodule

bind linkwitz_riley4_highpass lr4hp_chk #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lr4hp_chk (.*);
